>>> design/ccg_pkg.sv
package ccg_pkg;

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 15;
    localparam int ST_SQRT0   = 12;
    localparam int ST_LEN     = ST_SQRT0 + SQRT_STEPS + 1;
    localparam int ST_DIV0    = ST_LEN + 1;
    localparam int ST_OUT     = ST_DIV0 + DIV_STEPS;
    localparam int NUM_STAGES = ST_OUT + 1;

    localparam logic [14:0] ONE_Q14   = 15'd16384;
    localparam logic [14:0] SIN_A     = 15'd25736;
    localparam logic [14:0] SIN_B     = 15'd10512;
    localparam logic [14:0] SIN_C     = 15'd1160;
    localparam logic [15:0] QUARTER   = 16'd16384;
    localparam logic [31:0] DEPTH_MAX = 32'h7FFF_FFFF;

    typedef enum logic [1:0] {
        MODE_CIRCLE = 2'd0,
        MODE_BOX    = 2'd1,
        MODE_PLANE  = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t              mode;
        logic [30:0]        rad;
        logic signed [32:0] rx;
        logic signed [32:0] ry;
        logic signed [32:0] reach;
        logic [30:0]        hw;
        logic [30:0]        hh;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
    } geom_t;

    typedef struct packed {
        logic        neg;
        logic [14:0] u;
        logic [14:0] u2;
        logic [14:0] v;
    } trig_t;

    typedef struct packed {
        logic        hit;
        logic        pt;
        logic        zero;
        logic        sx;
        logic        sy;
        logic [31:0] ax;
        logic [31:0] ay;
        logic [31:0] r;
        logic [31:0] depth;
        logic [15:0] nx;
        logic [15:0] ny;
    } cont_t;

    // Value divided by 2^14, rounded half away from zero.
    function automatic logic signed [36:0] rnd14(input logic signed [49:0] v);
        logic [49:0] mag;
        logic [49:0] sum;
        logic signed [36:0] r;
        mag = v[49] ? 50'(-v) : 50'(v);
        sum = mag + 50'd8192;
        r   = $signed({1'b0, sum[49:14]});
        return v[49] ? -r : r;
    endfunction

    function automatic trig_t trig_init(input logic [15:0] a);
        trig_t       t;
        logic [29:0] sq;
        t.neg = a[15];
        t.u   = a[14] ? (ONE_Q14 - {1'b0, a[13:0]}) : {1'b0, a[13:0]};
        sq    = 30'(t.u) * 30'(t.u);
        t.u2  = sq[28:14];
        t.v   = '0;
        return t;
    endfunction

    function automatic trig_t trig_step1(input trig_t t);
        trig_t       o;
        logic [29:0] p;
        o   = t;
        p   = 30'(t.u2) * 30'(SIN_C);
        o.v = SIN_B - p[28:14];
        return o;
    endfunction

    function automatic trig_t trig_step2(input trig_t t);
        trig_t       o;
        logic [29:0] p;
        o   = t;
        p   = 30'(t.v) * 30'(t.u2);
        o.v = SIN_A - p[28:14];
        return o;
    endfunction

    function automatic logic signed [15:0] trig_out(input trig_t t);
        logic [29:0]        p;
        logic signed [15:0] m;
        p = 30'(t.v) * 30'(t.u);
        m = $signed(p[29:14]);
        return t.neg ? -m : m;
    endfunction

    function automatic logic [15:0] norm_out(input logic [14:0] q, input logic neg);
        logic [14:0]        qc;
        logic signed [15:0] m;
        qc = (q > ONE_Q14) ? ONE_Q14 : q;
        m  = $signed({1'b0, qc});
        return neg ? 16'(-m) : 16'(m);
    endfunction

endpackage

>>> design/circle_contact_generator_core.sv
// Narrow-phase contact test for one shape pair per request: circle against circle,
// circle against a rotated box, or circle against a plane. The block is a
// 62-stage pipeline that takes a new request every cycle while the output side
// does not stall. Most of its stages are the bit-per-stage square root of the
// squared distance (32 stages) and the 15-stage restoring divider that scales
// the contact normal. A stall on the output only backs up through stages that
// hold data, so bubbles fill.
module circle_contact_generator_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // mode[1:0], circle_x[33:2], circle_y[65:34], circle_radius[96:66],
    // other_x[128:97], other_y[160:129], other_a[192:161], other_b[224:193],
    // box_angle[240:225], zero fill above
    input  logic [247:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // depth[31:0], normal_x[47:32], normal_y[63:48]
    output logic [63:0]  m_tdata,
    // hit[0]
    output logic         m_tuser
);

    localparam int NS = ccg_pkg::NUM_STAGES;

    logic [NS-1:0] vld_reg;
    logic [NS:0]   en;

    always_comb begin
        en[NS] = m_tready;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= (k == 0) ? s_tvalid : vld_reg[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = vld_reg[NS-1];

    // ---------------- front end: differences, sine/cosine, plane ----------------
    ccg_pkg::geom_t             geo_reg [0:8];
    ccg_pkg::trig_t             trs_reg [0:2];
    ccg_pkg::trig_t             trc_reg [0:2];
    logic signed [15:0]         sn_reg  [3:6];
    logic signed [15:0]         cs_reg  [3:6];
    logic signed [48:0]         pl_px_reg, pl_py_reg;
    logic signed [49:0]         pl_sum_reg;
    logic signed [36:0]         pl_dist_reg;
    logic signed [37:0]         pl_diff_reg [4:8];
    logic                       pl_hit_reg  [4:8];

    ccg_pkg::geom_t geo_next;
    logic signed [31:0] in_cx, in_cy, in_ox, in_oy, in_oa, in_ob;

    always_comb begin
        in_cx = s_tdata[33:2];
        in_cy = s_tdata[65:34];
        in_ox = s_tdata[128:97];
        in_oy = s_tdata[160:129];
        in_oa = s_tdata[192:161];
        in_ob = s_tdata[224:193];
        geo_next.mode  = ccg_pkg::mode_t'(s_tdata[1:0]);
        geo_next.rad   = s_tdata[96:66];
        geo_next.rx    = 33'(in_cx) - 33'(in_ox);
        geo_next.ry    = 33'(in_cy) - 33'(in_oy);
        geo_next.reach = $signed({2'b00, s_tdata[96:66]}) + 33'(in_oa);
        geo_next.hw    = in_oa[31] ? 31'd0 : in_oa[30:0];
        geo_next.hh    = in_ob[31] ? 31'd0 : in_ob[30:0];
        geo_next.nx    = in_oa[15:0];
        geo_next.ny    = in_ob[15:0];
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            geo_reg[0] <= geo_next;
            trs_reg[0] <= ccg_pkg::trig_init(s_tdata[240:225]);
            trc_reg[0] <= ccg_pkg::trig_init(s_tdata[240:225] + ccg_pkg::QUARTER);
        end
        for (int k = 1; k <= 8; k++) begin
            if (en[k]) begin
                geo_reg[k] <= geo_reg[k-1];
            end
        end
        if (en[1]) begin
            trs_reg[1] <= ccg_pkg::trig_step1(trs_reg[0]);
            trc_reg[1] <= ccg_pkg::trig_step1(trc_reg[0]);
            pl_px_reg  <= 49'(geo_reg[0].rx) * 49'(geo_reg[0].nx);
            pl_py_reg  <= 49'(geo_reg[0].ry) * 49'(geo_reg[0].ny);
        end
        if (en[2]) begin
            trs_reg[2] <= ccg_pkg::trig_step2(trs_reg[1]);
            trc_reg[2] <= ccg_pkg::trig_step2(trc_reg[1]);
            pl_sum_reg <= 50'(pl_px_reg) + 50'(pl_py_reg);
        end
        if (en[3]) begin
            sn_reg[3]   <= ccg_pkg::trig_out(trs_reg[2]);
            cs_reg[3]   <= ccg_pkg::trig_out(trc_reg[2]);
            pl_dist_reg <= ccg_pkg::rnd14(pl_sum_reg);
        end
        for (int k = 4; k <= 6; k++) begin
            if (en[k]) begin
                sn_reg[k] <= sn_reg[k-1];
                cs_reg[k] <= cs_reg[k-1];
            end
        end
        if (en[4]) begin
            pl_diff_reg[4] <= $signed({7'b0, geo_reg[3].rad}) - 38'(pl_dist_reg);
            pl_hit_reg[4]  <= 38'(pl_dist_reg) < $signed({7'b0, geo_reg[3].rad});
        end
        for (int k = 5; k <= 8; k++) begin
            if (en[k]) begin
                pl_diff_reg[k] <= pl_diff_reg[k-1];
                pl_hit_reg[k]  <= pl_hit_reg[k-1];
            end
        end
    end

    // ---------------- box: rotate in, clamp, rotate back ----------------
    logic signed [48:0] bx_rxc_reg, bx_rys_reg, bx_ryc_reg, bx_rxs_reg;
    logic signed [36:0] bx_px_reg, bx_py_reg;
    logic signed [31:0] bx_cx_reg, bx_cy_reg;
    logic signed [47:0] bx_pxc_reg, bx_pys_reg, bx_pxs_reg, bx_pyc_reg;
    logic signed [36:0] bx_qx_reg, bx_qy_reg;

    logic signed [36:0] hw_s, hh_s, cx_c, cy_c;

    always_comb begin
        hw_s = $signed({6'b0, geo_reg[5].hw});
        hh_s = $signed({6'b0, geo_reg[5].hh});
        cx_c = bx_px_reg;
        if (bx_px_reg > hw_s) cx_c = hw_s;
        if (bx_px_reg < -hw_s) cx_c = -hw_s;
        cy_c = bx_py_reg;
        if (bx_py_reg > hh_s) cy_c = hh_s;
        if (bx_py_reg < -hh_s) cy_c = -hh_s;
    end

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            bx_rxc_reg <= 49'(geo_reg[3].rx) * 49'(cs_reg[3]);
            bx_rys_reg <= 49'(geo_reg[3].ry) * 49'(sn_reg[3]);
            bx_ryc_reg <= 49'(geo_reg[3].ry) * 49'(cs_reg[3]);
            bx_rxs_reg <= 49'(geo_reg[3].rx) * 49'(sn_reg[3]);
        end
        if (en[5]) begin
            bx_px_reg <= ccg_pkg::rnd14(50'(bx_rxc_reg) + 50'(bx_rys_reg));
            bx_py_reg <= ccg_pkg::rnd14(50'(bx_ryc_reg) - 50'(bx_rxs_reg));
        end
        if (en[6]) begin
            bx_cx_reg <= cx_c[31:0];
            bx_cy_reg <= cy_c[31:0];
        end
        if (en[7]) begin
            bx_pxc_reg <= 48'(bx_cx_reg) * 48'(cs_reg[6]);
            bx_pys_reg <= 48'(bx_cy_reg) * 48'(sn_reg[6]);
            bx_pxs_reg <= 48'(bx_cx_reg) * 48'(sn_reg[6]);
            bx_pyc_reg <= 48'(bx_cy_reg) * 48'(cs_reg[6]);
        end
        if (en[8]) begin
            bx_qx_reg <= ccg_pkg::rnd14(50'(bx_pxc_reg) - 50'(bx_pys_reg));
            bx_qy_reg <= ccg_pkg::rnd14(50'(bx_pxs_reg) + 50'(bx_pyc_reg));
        end
    end

    // ---------------- pair select and reach checks ----------------
    logic signed [37:0] pc_dx_reg, pc_dy_reg;
    logic signed [32:0] pc_r_reg;
    logic               pc_pt_reg;
    logic               pc_hit_reg;
    logic [31:0]        pc_depth_reg;
    logic [15:0]        pc_nx_reg, pc_ny_reg;

    logic signed [37:0] sel_dx, sel_dy;
    logic signed [32:0] sel_r;
    logic               sel_pt;
    logic [31:0]        pl_depth;

    always_comb begin
        sel_pt = (geo_reg[8].mode == ccg_pkg::MODE_CIRCLE) ||
                 (geo_reg[8].mode == ccg_pkg::MODE_BOX);
        if (geo_reg[8].mode == ccg_pkg::MODE_BOX) begin
            sel_dx = 38'(geo_reg[8].rx) - 38'(bx_qx_reg);
            sel_dy = 38'(geo_reg[8].ry) - 38'(bx_qy_reg);
            sel_r  = $signed({2'b00, geo_reg[8].rad});
        end else begin
            sel_dx = 38'(geo_reg[8].rx);
            sel_dy = 38'(geo_reg[8].ry);
            sel_r  = geo_reg[8].reach;
        end
        pl_depth = (pl_diff_reg[8] > $signed({6'b0, ccg_pkg::DEPTH_MAX})) ?
                   ccg_pkg::DEPTH_MAX : pl_diff_reg[8][31:0];
    end

    always_ff @(posedge aclk) begin
        if (en[9]) begin
            pc_dx_reg    <= sel_dx;
            pc_dy_reg    <= sel_dy;
            pc_r_reg     <= sel_r;
            pc_pt_reg    <= sel_pt;
            pc_hit_reg   <= (geo_reg[8].mode == ccg_pkg::MODE_PLANE) && pl_hit_reg[8];
            pc_depth_reg <= pl_depth;
            pc_nx_reg    <= geo_reg[8].nx;
            pc_ny_reg    <= geo_reg[8].ny;
        end
    end

    localparam int ST_LAST = ccg_pkg::ST_OUT - 1;
    ccg_pkg::cont_t cont_reg [10:ST_LAST];

    ccg_pkg::cont_t c10_next;
    logic [37:0]    abs_x, abs_y;
    logic           early;

    always_comb begin
        abs_x = pc_dx_reg[37] ? 38'(-pc_dx_reg) : 38'(pc_dx_reg);
        abs_y = pc_dy_reg[37] ? 38'(-pc_dy_reg) : 38'(pc_dy_reg);
        early = (pc_r_reg <= 33'sd0) || (abs_x >= {6'b0, pc_r_reg[31:0]}) ||
                (abs_y >= {6'b0, pc_r_reg[31:0]});
        c10_next.hit   = pc_pt_reg ? !early : pc_hit_reg;
        c10_next.pt    = pc_pt_reg;
        c10_next.zero  = 1'b0;
        c10_next.sx    = pc_dx_reg[37];
        c10_next.sy    = pc_dy_reg[37];
        c10_next.ax    = abs_x[31:0];
        c10_next.ay    = abs_y[31:0];
        c10_next.r     = pc_r_reg[31:0];
        c10_next.depth = pc_depth_reg;
        c10_next.nx    = pc_nx_reg;
        c10_next.ny    = pc_ny_reg;
    end

    logic [63:0] sq_ax_reg, sq_ay_reg, sq_r_reg;
    logic [63:0] sq_v_reg   [ccg_pkg::ST_SQRT0:ccg_pkg::ST_LEN-1];
    logic [63:0] sq_res_reg [ccg_pkg::ST_SQRT0:ccg_pkg::ST_LEN-1];
    logic [64:0] d2_sum;

    assign d2_sum = {1'b0, sq_ax_reg} + {1'b0, sq_ay_reg};

    always_ff @(posedge aclk) begin
        if (en[10]) begin
            cont_reg[10] <= c10_next;
        end
        if (en[11]) begin
            sq_ax_reg <= 64'(cont_reg[10].ax) * 64'(cont_reg[10].ax);
            sq_ay_reg <= 64'(cont_reg[10].ay) * 64'(cont_reg[10].ay);
            sq_r_reg  <= 64'(cont_reg[10].r) * 64'(cont_reg[10].r);
        end
        if (en[ccg_pkg::ST_SQRT0]) begin
            sq_v_reg[ccg_pkg::ST_SQRT0]   <= d2_sum[63:0];
            sq_res_reg[ccg_pkg::ST_SQRT0] <= '0;
        end
    end

    // Carry the contact record; fix the hit at the distance compare and the depth
    // once the length is known.
    for (genvar k = 11; k <= ST_LAST; k++) begin : g_cont
        ccg_pkg::cont_t c_next;
        if (k == ccg_pkg::ST_SQRT0) begin : g_cmp
            always_comb begin
                c_next      = cont_reg[k-1];
                c_next.hit  = cont_reg[k-1].pt ?
                              (cont_reg[k-1].hit && (d2_sum < {1'b0, sq_r_reg})) :
                              cont_reg[k-1].hit;
                c_next.zero = (d2_sum == 65'd0);
            end
        end else if (k == ccg_pkg::ST_LEN) begin : g_depth
            logic [31:0] diff;
            always_comb begin
                diff   = cont_reg[k-1].r - sq_res_reg[k-1][31:0];
                c_next = cont_reg[k-1];
                if (cont_reg[k-1].pt) begin
                    c_next.depth = diff[31] ? ccg_pkg::DEPTH_MAX : diff;
                end
            end
        end else begin : g_pass
            assign c_next = cont_reg[k-1];
        end
        always_ff @(posedge aclk) begin
            if (en[k]) begin
                cont_reg[k] <= c_next;
            end
        end
    end

    // ---------------- square root, one result bit per stage ----------------
    for (genvar i = 0; i < ccg_pkg::SQRT_STEPS; i++) begin : g_sqrt
        localparam int K  = ccg_pkg::ST_SQRT0 + 1 + i;
        localparam int SH = 2 * (ccg_pkg::SQRT_STEPS - 1 - i);
        logic [63:0] bit_w, trial;
        assign bit_w = 64'd1 << SH;
        assign trial = sq_res_reg[K-1] + bit_w;
        always_ff @(posedge aclk) begin
            if (en[K]) begin
                if (sq_v_reg[K-1] >= trial) begin
                    sq_v_reg[K]   <= sq_v_reg[K-1] - trial;
                    sq_res_reg[K] <= (sq_res_reg[K-1] >> 1) + bit_w;
                end else begin
                    sq_v_reg[K]   <= sq_v_reg[K-1];
                    sq_res_reg[K] <= sq_res_reg[K-1] >> 1;
                end
            end
        end
    end

    // ---------------- normal: component * 16384 / length ----------------
    logic [47:0] dv_remx_reg [ccg_pkg::ST_LEN:ST_LAST];
    logic [47:0] dv_remy_reg [ccg_pkg::ST_LEN:ST_LAST];
    logic [14:0] dv_qx_reg   [ccg_pkg::ST_LEN:ST_LAST];
    logic [14:0] dv_qy_reg   [ccg_pkg::ST_LEN:ST_LAST];
    logic [32:0] dv_den_reg  [ccg_pkg::ST_LEN:ST_LAST];
    logic [31:0] len_w;

    assign len_w = sq_res_reg[ccg_pkg::ST_LEN-1][31:0];

    always_ff @(posedge aclk) begin
        if (en[ccg_pkg::ST_LEN]) begin
            dv_remx_reg[ccg_pkg::ST_LEN] <= 48'({cont_reg[ccg_pkg::ST_LEN-1].ax, 15'b0}) +
                                            48'(len_w);
            dv_remy_reg[ccg_pkg::ST_LEN] <= 48'({cont_reg[ccg_pkg::ST_LEN-1].ay, 15'b0}) +
                                            48'(len_w);
            dv_qx_reg[ccg_pkg::ST_LEN]   <= '0;
            dv_qy_reg[ccg_pkg::ST_LEN]   <= '0;
            dv_den_reg[ccg_pkg::ST_LEN]  <= {len_w, 1'b0};
        end
    end

    for (genvar j = 0; j < ccg_pkg::DIV_STEPS; j++) begin : g_div
        localparam int K  = ccg_pkg::ST_DIV0 + j;
        localparam int SH = ccg_pkg::DIV_STEPS - 1 - j;
        logic [47:0] trial;
        logic [14:0] qbit;
        assign trial = 48'(dv_den_reg[K-1]) << SH;
        assign qbit  = 15'd1 << SH;
        always_ff @(posedge aclk) begin
            if (en[K]) begin
                dv_den_reg[K] <= dv_den_reg[K-1];
                if (dv_remx_reg[K-1] >= trial) begin
                    dv_remx_reg[K] <= dv_remx_reg[K-1] - trial;
                    dv_qx_reg[K]   <= dv_qx_reg[K-1] | qbit;
                end else begin
                    dv_remx_reg[K] <= dv_remx_reg[K-1];
                    dv_qx_reg[K]   <= dv_qx_reg[K-1];
                end
                if (dv_remy_reg[K-1] >= trial) begin
                    dv_remy_reg[K] <= dv_remy_reg[K-1] - trial;
                    dv_qy_reg[K]   <= dv_qy_reg[K-1] | qbit;
                end else begin
                    dv_remy_reg[K] <= dv_remy_reg[K-1];
                    dv_qy_reg[K]   <= dv_qy_reg[K-1];
                end
            end
        end
    end

    // ---------------- output register ----------------
    logic        o_hit_reg, o_hit_next;
    logic [31:0] o_depth_reg, o_depth_next;
    logic [15:0] o_nx_reg, o_nx_next, o_ny_reg, o_ny_next;
    ccg_pkg::cont_t cf;

    always_comb begin
        cf           = cont_reg[ST_LAST];
        o_hit_next   = cf.hit;
        o_depth_next = cf.hit ? cf.depth : 32'd0;
        o_nx_next    = cf.nx;
        o_ny_next    = cf.ny;
        if (cf.pt) begin
            o_nx_next = cf.zero ? 16'd0 : ccg_pkg::norm_out(dv_qx_reg[ST_LAST], cf.sx);
            o_ny_next = cf.zero ? 16'd0 : ccg_pkg::norm_out(dv_qy_reg[ST_LAST], cf.sy);
        end
        if (!cf.hit) begin
            o_nx_next = '0;
            o_ny_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[ccg_pkg::ST_OUT]) begin
            o_hit_reg   <= o_hit_next;
            o_depth_reg <= o_depth_next;
            o_nx_reg    <= o_nx_next;
            o_ny_reg    <= o_ny_next;
        end
    end

    assign m_tdata = {o_ny_reg, o_nx_reg, o_depth_reg};
    assign m_tuser = o_hit_reg;

    // A missed pair reports all fields as zero.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == 64'd0)
        else $error("miss with nonzero payload");

    // Every contact has a positive depth.
    a_hit_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[31:0] != 32'd0 && !m_tdata[31])
        else $error("contact without positive depth");

    // With the output register empty, nothing in the pipe can hold back the input.
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !vld_reg[NS-1] |-> s_tready)
        else $error("input stalled with empty output");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> vld_reg == '0)
        else $error("pipeline valid bits not cleared by reset");

endmodule

>>> tb/sv/circle_contact_checker.sv
module circle_contact_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [247:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [63:0]  m_tdata,
    input  logic         m_tuser,
    output int           fail_count,
    output int           contacts_pending,
    output int           contacts_seen,
    output int           hits_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        hit;
        logic [31:0] depth;
        logic [15:0] nx;
        logic [15:0] ny;
    } contact_t;

    contact_t contact_q[$];

    function automatic longint shr_round14(input longint v);
        longint m;
        m = v < 0 ? -v : v;
        m = (m + 8192) >>> 14;
        return v < 0 ? -m : m;
    endfunction

    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint sine_q14(input logic [15:0] a);
        longint unsigned u, u2, r;
        u  = a[14] ? 64'd16384 - a[13:0] : 64'(a[13:0]);
        u2 = (u * u) >> 14;
        r  = (64'd1160 * u2) >> 14;
        r  = 64'd10512 - r;
        r  = (r * u2) >> 14;
        r  = 64'd25736 - r;
        r  = (r * u) >> 14;
        return a[15] ? -longint'(r) : longint'(r);
    endfunction

    function automatic logic [15:0] unit_comp(input longint d, input longint unsigned len);
        longint unsigned m, q;
        longint s;
        m = d < 0 ? -d : d;
        q = (m * 32768 + len) / (2 * len);
        if (q > 16384)
            q = 16384;
        s = d < 0 ? -longint'(q) : longint'(q);
        return s[15:0];
    endfunction

    function automatic logic [31:0] clip_depth(input longint d);
        if (d > 64'sh7FFF_FFFF)
            d = 64'sh7FFF_FFFF;
        return d[31:0];
    endfunction

    function automatic contact_t reach_contact(input longint dx, input longint dy,
                                               input longint r);
        contact_t c;
        longint unsigned ax, ay, ur, r2, d2, len;
        c  = '0;
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        if (r <= 0)
            return c;
        ur = r;
        if (ax >= ur || ay >= ur)
            return c;
        r2 = ur * ur;
        d2 = ax * ax;
        if (ay * ay >= r2 - d2)
            return c;
        d2 = d2 + ay * ay;
        len = floor_root(d2);
        c.hit   = 1'b1;
        c.depth = clip_depth(r - longint'(len));
        if (d2 != 0) begin
            c.nx = unit_comp(dx, len);
            c.ny = unit_comp(dy, len);
        end
        return c;
    endfunction

    function automatic contact_t predict_contact(input logic [247:0] d);
        contact_t        c;
        ccg_pkg::mode_t  md;
        longint   cx, cy, rad, ox, oy, oa, ob, rx, ry, s, co, hw, hh;
        longint   px, py, qx, qy, nx, ny, plane_dist;
        logic [15:0] ang;
        c   = '0;
        md  = ccg_pkg::mode_t'(d[1:0]);
        cx  = $signed(d[33:2]);
        cy  = $signed(d[65:34]);
        rad = d[96:66];
        ox  = $signed(d[128:97]);
        oy  = $signed(d[160:129]);
        oa  = $signed(d[192:161]);
        ob  = $signed(d[224:193]);
        ang = d[240:225];
        rx  = cx - ox;
        ry  = cy - oy;
        case (md)
            ccg_pkg::MODE_CIRCLE: begin
                c = reach_contact(rx, ry, rad + oa);
            end
            ccg_pkg::MODE_BOX: begin
                s  = sine_q14(ang);
                co = sine_q14(ang + 16'd16384);
                hw = oa < 0 ? 0 : oa;
                hh = ob < 0 ? 0 : ob;
                px = shr_round14(rx * co + ry * s);
                py = shr_round14(ry * co - rx * s);
                if (px > hw) px = hw;
                if (px < -hw) px = -hw;
                if (py > hh) py = hh;
                if (py < -hh) py = -hh;
                qx = shr_round14(px * co - py * s);
                qy = shr_round14(px * s + py * co);
                c = reach_contact(rx - qx, ry - qy, rad);
            end
            ccg_pkg::MODE_PLANE: begin
                nx   = $signed(d[176:161]);
                ny   = $signed(d[208:193]);
                plane_dist = shr_round14(rx * nx + ry * ny);
                if (plane_dist < rad) begin
                    c.hit   = 1'b1;
                    c.depth = clip_depth(rad - plane_dist);
                    c.nx    = nx[15:0];
                    c.ny    = ny[15:0];
                end
            end
            default: ;
        endcase
        return c;
    endfunction

    assign contacts_pending = contact_q.size();

    always @(posedge aclk) begin
        contact_t e;
        if (!aresetn) begin
            fail_count    <= 0;
            contacts_seen <= 0;
            hits_seen     <= 0;
        end else begin
            if (s_tvalid && s_tready)
                contact_q = {contact_q, predict_contact(s_tdata)};
            if (m_tvalid && m_tready) begin
                contacts_seen <= contacts_seen + 1;
                hits_seen     <= hits_seen + m_tuser;
                if (contact_q.size() == 0) begin
                    $display("%0t: unexpected result hit=%b data=%h", $time, m_tuser, m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    e = contact_q.pop_front();
                    if (e.hit !== m_tuser || e.depth !== m_tdata[31:0] ||
                        e.nx !== m_tdata[47:32] || e.ny !== m_tdata[63:48]) begin
                        $display("%0t: mismatch expected hit=%b depth=%h nx=%h ny=%h",
                                 $time, e.hit, e.depth, e.nx, e.ny);
                        $display("%0t:          actual   hit=%b depth=%h nx=%h ny=%h",
                                 $time, m_tuser, m_tdata[31:0], m_tdata[47:32],
                                 m_tdata[63:48]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

>>> tb/sv/circle_contact_generator_core_tb.sv
module circle_contact_generator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 700;
    localparam int STALL_LIMIT  = 3000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [247:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;
    logic         m_tuser;
    int           fail_count, contacts_pending, contacts_seen, hits_seen;
    int           requests_sent = 0;
    int           idle_cycles = 0;

    always #6 aclk = ~aclk;

    circle_contact_generator_core u_top (.*);

    circle_contact_checker u_chk (.*);

    function automatic logic [247:0] pack_request(ccg_pkg::mode_t md, int cx, int cy,
                                                  logic [30:0] rad, int ox, int oy,
                                                  int oa, int ob, logic [15:0] ang);
        return {7'd0, ang, ob, oa, oy, ox, rad, cy, cx, md};
    endfunction

    function automatic int near_offset(int scale);
        int v;
        v = int'($urandom_range((1 << scale) - 1, 0));
        return $urandom_range(1, 0) ? -v : v;
    endfunction

    function automatic logic [247:0] random_request();
        ccg_pkg::mode_t md;
        int    scale, cx, cy, nx, ny;
        md = ccg_pkg::mode_t'($urandom_range(3, 0));
        if ($urandom_range(99, 0) < 20)
            return pack_request(md, $urandom, $urandom, 31'($urandom), $urandom, $urandom,
                                $urandom, $urandom, 16'($urandom));
        scale = $urandom_range(28, 4);
        cx = $urandom;
        cy = $urandom;
        nx = $urandom_range(32768, 0) - 16384;
        ny = $urandom_range(32768, 0) - 16384;
        if (md == ccg_pkg::MODE_PLANE)
            return pack_request(md, cx, cy, 31'($urandom_range((1 << scale) - 1, 0)),
                                cx + near_offset(scale), cy + near_offset(scale),
                                {16'($urandom), 16'(nx)}, {16'($urandom), 16'(ny)},
                                16'($urandom));
        return pack_request(md, cx, cy, 31'($urandom_range((1 << scale) - 1, 0)),
                            cx + near_offset(scale), cy + near_offset(scale),
                            near_offset(scale), near_offset(scale), 16'($urandom));
    endfunction

    function automatic bit calm_phase();
        return requests_sent >= 350 && requests_sent < 450;
    endfunction

    task automatic send_request(input logic [247:0] d);
        logic rdy;
        while (!calm_phase() && $urandom_range(99, 0) < 11) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do begin
            @(negedge aclk);
            rdy = s_tready;
            @(posedge aclk);
        end while (!rdy);
        requests_sent++;
    endtask

    // Receiver: random stalls, one long hold-off that backs up the pipeline.
    initial begin
        bit held;
        held = 0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (!held && requests_sent >= 150) begin
                held = 1;
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
            end else begin
                m_tready <= calm_phase() || $urandom_range(99, 0) >= 11;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > STALL_LIMIT) begin
                $display("timeout: no request or result moved for %0d cycles", idle_cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // Directed requests: unsupported pair, coincident centers, extremes, box
        // quarter turns, negative extents, non-positive reach, depth saturation.
        send_request(pack_request(ccg_pkg::MODE_NONE, 0, 0, 31'h7FFF_FFFF, 0, 0,
                                  100, 100, 0));
        send_request(pack_request(ccg_pkg::MODE_CIRCLE, 1000, -500, 31'h10000,
                                  1000, -500, 32'h10000, 0, 0));
        send_request(pack_request(ccg_pkg::MODE_CIRCLE, 32'h10000, 0, 31'h8000, 0, 0,
                                  32'h10000, 0, 0));
        send_request(pack_request(ccg_pkg::MODE_CIRCLE, 32'h7FFF_FFFF, 32'h8000_0000,
                                  31'h7FFF_FFFF, 32'h7FFF_0000, 32'h8000_1000,
                                  32'h7FFF_FFFF, 0, 0));
        send_request(pack_request(ccg_pkg::MODE_CIRCLE, 0, 0, 31'd0, 5, 5, -10, 0, 0));
        send_request(pack_request(ccg_pkg::MODE_CIRCLE, 0, 0, 31'd0, 0, 0, 0, 0, 0));
        send_request(pack_request(ccg_pkg::MODE_CIRCLE, 32'h8000_0000, 32'h8000_0000,
                                  31'h100, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                  32'h7FFF_FFFF, 32'hFFFF_FFFF, 0));
        for (int q = 0; q < 5; q++)
            send_request(pack_request(ccg_pkg::MODE_BOX, 32'h30000, 32'h18000,
                                      31'h10000, 0, 0, 32'h20000, 32'h10000,
                                      (q == 4) ? 16'hFFFF : 16'(q * 16384 + 2000)));
        send_request(pack_request(ccg_pkg::MODE_BOX, 100, -200, 31'h4000, 0, 0,
                                  32'h10000, 32'h10000, 16'h2000));
        send_request(pack_request(ccg_pkg::MODE_BOX, 32'h20000, 0, 31'h18000, 0, 0, -5,
                                  32'h8000_0000, 16'h1234));
        send_request(pack_request(ccg_pkg::MODE_BOX, 32'h8000_0000, 32'h7FFF_FFFF,
                                  31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h8000));
        send_request(pack_request(ccg_pkg::MODE_PLANE, 32'h8000_0000, 0, 31'h7FFF_FFFF,
                                  32'h7FFF_FFFF, 0, 16384, 0, 0));
        send_request(pack_request(ccg_pkg::MODE_PLANE, 0, 32'h20000, 31'h10000, 0, 0,
                                  0, 16384, 0));
        send_request(pack_request(ccg_pkg::MODE_PLANE, 0, 32'h8000, 31'h10000, 0, 0,
                                  32'hFFFF_C000, 32'h1234_2000, 0));
        send_request(pack_request(ccg_pkg::MODE_PLANE, 0, 0, 31'd0, 0, 0, 32'h8000,
                                  32'h8000, 0));
        send_request(pack_request(ccg_pkg::MODE_PLANE, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                  31'd0, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_8000,
                                  32'hFFFF_7FFF, 16'hFFFF));
        repeat (RANDOM_ITEMS)
            send_request(random_request());
        s_tvalid <= 1'b0;
        while (contacts_pending != 0)
            @(posedge aclk);
        repeat (100) @(posedge aclk);
        $display("Sent %0d shape-pair requests over all pair kinds; %0d results checked,",
                 requests_sent, contacts_seen);
        $display("%0d of them contacts, including a 400-cycle output hold-off.", hits_seen);
        if (fail_count == 0 && contacts_pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> filelist.f
design/ccg_pkg.sv
design/circle_contact_generator_core.sv
tb/sv/circle_contact_checker.sv
tb/sv/circle_contact_generator_core_tb.sv
